// ===== src/small_set_key_sorter_assert.svh =====
// assertion macros shared by the sorter rtl
`ifndef SMALL_SET_KEY_SORTER_ASSERT_SVH
`define SMALL_SET_KEY_SORTER_ASSERT_SVH

// property checked on every clock edge outside reset
`define SSKS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SSKS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ssks_pkg.sv =====
// shared types, constants and compare function of the small set key sorter
`default_nettype none

package ssks_pkg;

    localparam int KEY_W     = 32;
    localparam int MAX_ELEMS = 32;
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        key_t key;
        logic valid;
        logic gt;
    } cell_out_t;

    // true when a must follow b in ascending order
    function automatic logic key_gt(input key_t a, input key_t b, input logic sgn);
        key_t fa;
        key_t fb;
        fa = a;
        fb = b;
        if (sgn) begin
            fa[KEY_W-1] = ~a[KEY_W-1];
            fb[KEY_W-1] = ~b[KEY_W-1];
        end
        return fa > fb;
    endfunction

endpackage

`default_nettype wire

// ===== src/small_set_key_sorter.sv =====
// small set key sorter: loads up to 32 keys in order, then emits them ascending
// the first sorted word is valid the cycle after the last key is accepted
// a new set is not accepted until every word of the current set is read out
// keys are inserted in order; readout shifts one word per cycle while m_tready is high
// reset: synchronous active-low aresetn empties the cells, sets compare_signed to 1
`default_nettype none

module small_set_key_sorter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // key_in
    input  wire logic        s_tlast,  // last_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // key_out
    output logic             m_tlast,  // last_out
    output logic             m_tuser,  // overflow
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ssks_pkg::*;
    `include "small_set_key_sorter_assert.svh"

    localparam logic       ST_LOAD = 1'b0;
    localparam logic       ST_EMIT = 1'b1;
    localparam logic [2:0] ADDR_COMPARE_SIGNED = 3'd0;

    logic       state_reg;
    logic       state_next;
    cnt_t       count_reg;
    cnt_t       count_next;
    logic       drop_reg;
    logic       drop_next;
    logic       signed_reg;
    logic       in_acc;
    logic       out_acc;
    logic       full;
    cell_ctrl_t ctrl;
    cell_out_t  head;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COMPARE_SIGNED) ? {31'b0, signed_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_COMPARE_SIGNED) begin
            signed_reg <= pwdata[0];
        end
    end

    assign full     = (count_reg == CNT_W'(MAX_ELEMS));
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    assign ctrl.load  = in_acc && !full;
    assign ctrl.shift = out_acc;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        state_next = ST_LOAD;
                        drop_next  = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    ssks_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .cmp_signed (signed_reg),
        .new_key    (s_tdata),
        .head       (head)
    );

    assign m_tdata = head.key;
    assign m_tlast = (count_reg == CNT_W'(1));
    assign m_tuser = drop_reg;

    `SSKS_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(MAX_ELEMS), "count past capacity")
    `SSKS_ASSERT(a_emit_has_data, aclk, aresetn, m_tvalid |-> (count_reg != '0 && head.valid), "emit with empty head")
    `SSKS_ASSERT(a_drop_flag, aclk, aresetn, (in_acc && full) |=> drop_reg, "dropped key not flagged")
    `SSKS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_LOAD && count_reg == '0), "reset not idle")

endmodule

`default_nettype wire

// ===== src/ssks_cell.sv =====
// one sorter cell: holds a key, inserts in order, shifts toward the head on readout
`default_nettype none

module ssks_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ssks_pkg::cell_ctrl_t ctrl,
    input  wire logic               cmp_signed,
    input  wire ssks_pkg::key_t     new_key,
    input  wire ssks_pkg::cell_out_t left,
    input  wire ssks_pkg::cell_out_t right,
    output ssks_pkg::cell_out_t     dout
);
    import ssks_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;
    logic gt;

    assign gt = !valid_reg || key_gt(key_reg, new_key, cmp_signed);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            key_next   = right.key;
            valid_next = right.valid;
        end else if (ctrl.load && gt) begin
            if (left.gt) begin
                key_next   = left.key;
                valid_next = left.valid;
            end else begin
                key_next   = new_key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign dout.key   = key_reg;
    assign dout.valid = valid_reg;
    assign dout.gt    = gt;

endmodule

`default_nettype wire

// ===== src/ssks_chain.sv =====
// row of sorter cells wired to their neighbors
`default_nettype none

module ssks_chain (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ssks_pkg::cell_ctrl_t ctrl,
    input  wire logic                 cmp_signed,
    input  wire ssks_pkg::key_t       new_key,
    output ssks_pkg::cell_out_t       head
);
    import ssks_pkg::*;

    cell_out_t cells [MAX_ELEMS];
    cell_out_t edge_fill;

    assign edge_fill = '{key: '0, valid: 1'b0, gt: 1'b0};

    genvar i;
    generate
        for (i = 0; i < MAX_ELEMS; i++) begin : g_cell
            cell_out_t left_n;
            cell_out_t right_n;
            if (i == 0) begin : g_first
                assign left_n = edge_fill;
            end else begin : g_mid_l
                assign left_n = cells[i-1];
            end
            if (i == MAX_ELEMS - 1) begin : g_last
                assign right_n = edge_fill;
            end else begin : g_mid_r
                assign right_n = cells[i+1];
            end
            ssks_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .cmp_signed (cmp_signed),
                .new_key    (new_key),
                .left       (left_n),
                .right      (right_n),
                .dout       (cells[i])
            );
        end
    endgenerate

    assign head = cells[0];

endmodule

`default_nettype wire
